@@ design/lmds_pkg.sv @@
`timescale 1ns / 1ps

package lmds_pkg;

   localparam int SEG_W           = 4;
   localparam int WORD_W          = 6;
   localparam int INDEX_W         = 7;
   localparam int POS_W           = 3;
   localparam int STORE_DEPTH     = 16;
   localparam int HOUR_POS        = 5;
   localparam int MINUTES_PER_SEG = 5;
   localparam int MINUTE_LIMIT    = 80;
   localparam int GREEN_SEG       = 12;
   localparam int RED_SEG         = 13;
   localparam int MIRROR_LIMIT    = 12;
   localparam int RECIP_5         = 205;
   localparam int RECIP_SHIFT     = 10;
   localparam int PROD_W          = 15;

   localparam int DEF_NUM_SEGMENTS      = 16;
   localparam int DEF_TICKS_PER_SEGMENT = 4;

   typedef enum logic [2:0] {
      MODE_TICK   = 3'd0,
      MODE_MINUTE = 3'd1,
      MODE_HOUR   = 3'd2,
      MODE_CENTER = 3'd3,
      MODE_CLEAR  = 3'd4,
      MODE_COMMIT = 3'd5
   } mode_type;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [INDEX_W-1:0] led_index;
      logic               led_on;
      logic               red_on;
      logic               green_on;
   } item_type;

   typedef struct packed {
      logic     update;
      item_type item;
   } store_cmd_type;

   // The index divided by five, by multiplying with a scaled reciprocal.
   function automatic logic [SEG_W-1:0] minute_segment(input logic [INDEX_W-1:0] idx);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(idx) * PROD_W'(RECIP_5);
      return SEG_W'(prod >> RECIP_SHIFT);
   endfunction

   function automatic logic [POS_W-1:0] minute_position(input logic [INDEX_W-1:0] idx,
                                                         input logic [SEG_W-1:0]   seg);
      logic [INDEX_W-1:0] base;
      base = INDEX_W'(seg) * INDEX_W'(MINUTES_PER_SEG);
      return POS_W'(idx - base);
   endfunction

endpackage

@@ design/lmds_store.sv @@
`timescale 1ns / 1ps

module lmds_store
   import lmds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  store_cmd_type     cmd,
   input  logic [SEG_W-1:0]  draw_addr,
   output word_type          draw_word
);

   word_type edit_ff [STORE_DEPTH];
   word_type edit_in [STORE_DEPTH];
   word_type draw_ff [STORE_DEPTH];
   word_type draw_in [STORE_DEPTH];

   logic [SEG_W-1:0] min_seg;
   logic [POS_W-1:0] min_pos;

   assign min_seg   = minute_segment(cmd.item.led_index);
   assign min_pos   = minute_position(cmd.item.led_index, min_seg);
   assign draw_word = draw_ff[draw_addr];

   always_comb begin
      edit_in = edit_ff;
      draw_in = draw_ff;
      if (cmd.update) begin
         unique case (mode_type'(cmd.item.mode))
            MODE_MINUTE: begin
               if (cmd.item.led_index < INDEX_W'(MINUTE_LIMIT)) begin
                  edit_in[min_seg][min_pos] = cmd.item.led_on;
               end
            end
            MODE_HOUR: begin
               if (cmd.item.led_index < INDEX_W'(STORE_DEPTH)) begin
                  edit_in[SEG_W'(cmd.item.led_index)][HOUR_POS] = cmd.item.led_on;
               end
            end
            MODE_CENTER: begin
               edit_in[RED_SEG][0]   = cmd.item.red_on;
               edit_in[GREEN_SEG][0] = cmd.item.green_on;
            end
            MODE_CLEAR: begin
               edit_in = '{default: '0};
            end
            MODE_COMMIT: begin
               draw_in = edit_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edit_ff <= '{default: '0};
         draw_ff <= '{default: '0};
      end else begin
         edit_ff <= edit_in;
         draw_ff <= draw_in;
      end
   end

endmodule

@@ design/lmds_scan.sv @@
`timescale 1ns / 1ps

module lmds_scan
   import lmds_pkg::*;
#(
   parameter int NUM_SEGMENTS      = DEF_NUM_SEGMENTS,
   parameter int TICKS_PER_SEGMENT = DEF_TICKS_PER_SEGMENT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              tick_fire,
   input  word_type          draw_word,
   input  logic              rsp_tready,
   output logic [SEG_W-1:0]  scan_segment,
   output logic              out_free,
   output logic              rsp_valid,
   output logic [SEG_W-1:0]  rsp_mux_select,
   output word_type          rsp_led_pins
);

   localparam int LEVEL_W = (TICKS_PER_SEGMENT > 1) ? $clog2(TICKS_PER_SEGMENT) : 1;

   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic [SEG_W-1:0]   seg_ff;
   logic [SEG_W-1:0]   seg_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [SEG_W-1:0]   mux_ff;
   word_type           pins_ff;
   word_type           pins_in;

   assign scan_segment   = seg_ff;
   assign out_free       = !rsp_valid_ff || rsp_tready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mux_select = mux_ff;
   assign rsp_led_pins   = pins_ff;

   // Odd segments below twelve have their minute LEDs wired in reverse order.
   always_comb begin
      pins_in = draw_word;
      if (seg_ff[0] && (seg_ff < SEG_W'(MIRROR_LIMIT))) begin
         for (int i = 0; i < MINUTES_PER_SEG; i++) begin
            pins_in[i] = draw_word[MINUTES_PER_SEG - 1 - i];
         end
      end
   end

   always_comb begin
      level_in = level_ff;
      seg_in   = seg_ff;
      if (tick_fire) begin
         if (level_ff == LEVEL_W'(TICKS_PER_SEGMENT - 1)) begin
            level_in = '0;
            if (seg_ff == SEG_W'(NUM_SEGMENTS - 1)) begin
               seg_in = '0;
            end else begin
               seg_in = seg_ff + SEG_W'(1);
            end
         end else begin
            level_in = level_ff + LEVEL_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tick_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         seg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         mux_ff  <= seg_ff;
         pins_ff <= pins_in;
      end
   end

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(TICKS_PER_SEGMENT - 1))
      else $error("Level counter has left its range.");

endmodule

@@ design/led_mux_display_scan_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Ports        Payload
// request   in         req_t*       mode, led_index, led_on, red_on, green_on
// response  out        rsp_t*       mux_select, led_pins (tick requests only)
//
// One request is taken per cycle unless a tick is stalled. A request is registered on
// entry and acted on in the next cycle unless stalled, a tick loading the output register.
// Reset clears both segment stores, the level counter and the scan segment.
// A stalled response holds a waiting tick request in the input register, and with it every
// request behind it; edit requests ahead of that tick have already completed.

module led_mux_display_scan_top
   import lmds_pkg::*;
#(
   parameter int NUM_SEGMENTS      = DEF_NUM_SEGMENTS,
   parameter int TICKS_PER_SEGMENT = DEF_TICKS_PER_SEGMENT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode [2:0], led_index [9:3], led_on [10], red_on [11], green_on [12], zeros above
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mux_select [3:0], led_pins [9:4], zeros above
   output logic [15:0] rsp_tdata
);

   logic             req_valid_ff;
   logic             req_valid_in;
   item_type         item_ff;
   item_type         item_in;
   logic             is_tick;
   logic             advance;
   logic             tick_fire;
   logic             out_free;
   logic [SEG_W-1:0] scan_segment;
   word_type         draw_word;
   logic [SEG_W-1:0] mux_select;
   word_type         led_pins;
   store_cmd_type    store_cmd;

   assign item_in.mode      = req_tdata[2:0];
   assign item_in.led_index = req_tdata[9:3];
   assign item_in.led_on    = req_tdata[10];
   assign item_in.red_on    = req_tdata[11];
   assign item_in.green_on  = req_tdata[12];

   assign is_tick    = (item_ff.mode == MODE_TICK);
   assign advance    = req_valid_ff && (!is_tick || out_free);
   assign tick_fire  = advance && is_tick;
   assign req_tready = !req_valid_ff || advance;

   assign store_cmd.update = advance;
   assign store_cmd.item   = item_ff;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   lmds_store u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (store_cmd),
      .draw_addr (scan_segment),
      .draw_word (draw_word)
   );

   lmds_scan #(
      .NUM_SEGMENTS      (NUM_SEGMENTS),
      .TICKS_PER_SEGMENT (TICKS_PER_SEGMENT)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .tick_fire      (tick_fire),
      .draw_word      (draw_word),
      .rsp_tready     (rsp_tready),
      .scan_segment   (scan_segment),
      .out_free       (out_free),
      .rsp_valid      (rsp_tvalid),
      .rsp_mux_select (mux_select),
      .rsp_led_pins   (led_pins)
   );

   assign rsp_tdata = {6'd0, led_pins, mux_select};

   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(tick_fire))
      else $error("A response appeared without a tick request.");

   a_segment_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mux_select < SEG_W'(NUM_SEGMENTS - 1) ||
                      mux_select == SEG_W'(NUM_SEGMENTS - 1)))
      else $error("Response names a segment that is never scanned.");

   a_tick_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && is_tick && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("A tick request was taken while the response register was full.");

endmodule
